>>> hw/rtl/fla_pkg.sv
// shared types and constants for the free list slot allocator
package fla_pkg;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned SLOT_W = $clog2(DEPTH);

  localparam logic [SLOT_W-1:0] END_MARK   = SLOT_W'(DEPTH - 1);
  localparam logic [SLOT_W-1:0] SIZE_RESET = SLOT_W'(DEPTH - 1);

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot_in;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] slot_out;
    logic [SLOT_W-1:0] free_count;
  } out_t;

  typedef struct packed {
    logic              used;
    logic [SLOT_W-1:0] link;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] size;
  } init_req_t;

endpackage

>>> hw/rtl/free_list_slot_allocator.sv
// free list slot allocator top level
//
// usage:
//   raise start with in_item while busy is low; func 0 allocates the head
//   slot, func 1 releases in_item.slot_in. the item is taken on that edge.
//   busy is high for one cycle while the link memory is read and rewritten,
//   so no new item is taken while busy is high; the single memory read port and
//   the read-modify-write of the head slot make it finish one item first.
//   out_valid pulses for one cycle with out_item, registered out of S_EXEC;
//   the receiver cannot stall, a new item may start while out_valid is high.
//   cfg_valid/cfg_data rewrites the managed size at any time (cfg_ready is
//   always high); write it only while no item is in flight. it rebuilds the
//   free list at once, without a clearing pass: a watermark marks slots not
//   touched since the rebuild, which read as free and linked to the slot below.
//   reset (rst_n low, synchronous) builds the list for size 1023, head at
//   slot 1022; no result is pending after reset.
module free_list_slot_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  fla_pkg::in_t               in_item,
  output logic                       out_valid,
  output fla_pkg::out_t              out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fla_pkg::SLOT_W-1:0] cfg_data
);
  import fla_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic              func_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] head_r, head_nxt;
  logic [SLOT_W-1:0] free_r, free_nxt;
  logic [SLOT_W-1:0] size_r, size_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  logic              accept;
  logic              cfg_acc;
  logic [SLOT_W-1:0] rd_addr;
  wr_req_t           wr;
  init_req_t         init;
  entry_t            rd_entry;

  assign busy      = (state_r == S_EXEC);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign rd_addr   = (in_item.func == FUNC_RELEASE) ? in_item.slot_in : head_r;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign init.en   = cfg_acc;
  assign init.size = cfg_data;

  fla_link_store u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (accept),
    .rd_addr  (rd_addr),
    .wr       (wr),
    .init     (init),
    .rd_entry (rd_entry)
  );

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    size_nxt      = size_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    wr            = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt          = S_IDLE;
        out_valid_nxt      = 1'b1;
        out_nxt.ok         = 1'b0;
        out_nxt.slot_out   = '0;
        if (func_r == FUNC_ALLOC) begin
          if (head_r != END_MARK) begin
            out_nxt.ok       = 1'b1;
            out_nxt.slot_out = head_r;
            wr.en            = 1'b1;
            wr.addr          = head_r;
            wr.data.used     = 1'b1;
            wr.data.link     = rd_entry.link;
            head_nxt         = rd_entry.link;
            if (free_r != '0) begin
              free_nxt = free_r - SLOT_W'(1);
            end
          end
        end else begin
          if ((slot_r < size_r) && rd_entry.used) begin
            out_nxt.ok   = 1'b1;
            wr.en        = 1'b1;
            wr.addr      = slot_r;
            wr.data.used = 1'b0;
            wr.data.link = head_r;
            head_nxt     = slot_r;
            free_nxt     = free_r + SLOT_W'(1);
          end
        end
        out_nxt.free_count = free_nxt;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // size write rebuilds the list
    if (cfg_acc) begin
      size_nxt = cfg_data;
      free_nxt = cfg_data;
      head_nxt = (cfg_data == '0) ? END_MARK : (cfg_data - SLOT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= SIZE_RESET - SLOT_W'(1);
      free_r      <= SIZE_RESET;
      size_r      <= SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (accept) begin
      func_r <= in_item.func;
      slot_r <= in_item.slot_in;
    end
  end

`ifndef SYNTH
  a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == S_EXEC))
    else $error("result without an item in execution");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_acc) |=> (busy && out_valid_r == 1'b0))
    else $error("accepted item did not enter execution");

  a_free_within_size: assert property (@(posedge clk) disable iff (!rst_n)
    free_r <= size_r)
    else $error("free count exceeds managed size");

  a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == END_MARK) == (free_r == '0))
    else $error("head and free count disagree on empty list");
`endif

endmodule

>>> hw/rtl/fla_link_store.sv
// link and used-flag memory with a watermark that stands in for the initial fill
module fla_link_store (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [fla_pkg::SLOT_W-1:0] rd_addr,
  input  fla_pkg::wr_req_t          wr,
  input  fla_pkg::init_req_t        init,
  output fla_pkg::entry_t           rd_entry
);
  import fla_pkg::*;

  entry_t            mem [DEPTH];
  entry_t            rd_data_r;
  logic [SLOT_W-1:0] rd_addr_r;
  // slots below the watermark have not been touched since the list was built
  logic [SLOT_W-1:0] mark_r;
  logic [SLOT_W-1:0] mark_nxt;
  logic              pristine;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_comb begin
    mark_nxt = mark_r;
    if (init.en) begin
      mark_nxt = init.size;
    end else if (wr.en && wr.data.used && (wr.addr < mark_r)) begin
      mark_nxt = wr.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= SIZE_RESET;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign pristine = (rd_addr_r < mark_r);

  always_comb begin
    if (pristine) begin
      rd_entry.used = 1'b0;
      rd_entry.link = rd_addr_r - SLOT_W'(1);
    end else begin
      rd_entry = rd_data_r;
    end
  end

endmodule

>>> bench/fla_checker.sv
// checker that predicts and compares the slot allocator results
`timescale 1ns / 100ps
module fla_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  fla_pkg::in_t               in_item,
  input  logic                       out_valid,
  input  fla_pkg::out_t              out_item,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [fla_pkg::SLOT_W-1:0] cfg_data,
  output int                         fail_count,
  output int                         open_count
);
  import fla_pkg::*;

  logic [SLOT_W-1:0] link_mem [DEPTH];
  logic              used_mem [DEPTH];
  logic [SLOT_W-1:0] head_slot;
  logic [SLOT_W-1:0] free_total;
  logic [SLOT_W-1:0] managed_size;
  out_t              pending_results [$];

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("fla_checker: %s mismatch, got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  function automatic void rebuild_list(input logic [SLOT_W-1:0] size);
    logic [SLOT_W-1:0] capped;
    capped = (size > END_MARK) ? END_MARK : size;
    managed_size = capped;
    for (int i = 0; i < DEPTH; i++) begin
      link_mem[i] = (i == 0) ? END_MARK : SLOT_W'(i - 1);
      used_mem[i] = 1'b0;
    end
    head_slot  = (capped == '0) ? END_MARK : capped - 1'b1;
    free_total = capped;
  endfunction

  function automatic out_t allocate_or_release(input in_t op);
    out_t res;
    res = '0;
    if (op.func == FUNC_ALLOC) begin
      if (head_slot != END_MARK) begin
        res.slot_out = head_slot;
        used_mem[head_slot] = 1'b1;
        head_slot = link_mem[head_slot];
        if (free_total != '0) free_total = free_total - 1'b1;
        res.ok = 1'b1;
      end
    end else if (op.slot_in < managed_size && used_mem[op.slot_in]) begin
      used_mem[op.slot_in] = 1'b0;
      link_mem[op.slot_in] = head_slot;
      head_slot = op.slot_in;
      free_total = free_total + 1'b1;
      res.ok = 1'b1;
    end
    res.free_count = free_total;
    return res;
  endfunction

  always @(posedge clk) begin : check_edge
    out_t want;
    if (!rst_n) begin
      rebuild_list(SIZE_RESET);
      pending_results.delete();
    end else begin
      if (out_valid !== 1'b0) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result slot_out", out_item.slot_out, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_item.ok !== want.ok)
            report_mismatch("ok", out_item.ok, want.ok);
          if (out_item.slot_out !== want.slot_out)
            report_mismatch("slot_out", out_item.slot_out, want.slot_out);
          if (out_item.free_count !== want.free_count)
            report_mismatch("free_count", out_item.free_count, want.free_count);
        end
      end
      if (cfg_valid && cfg_ready) rebuild_list(cfg_data);
      if (start && !busy) pending_results.push_back(allocate_or_release(in_item));
    end
    open_count = pending_results.size();
  end

endmodule

>>> bench/tb_top.sv
// testbench top: clock, reset, stimulus and verdict for the slot allocator
`timescale 1ns / 100ps
module tb_top;
  import fla_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              start     = 1'b0;
  in_t               in_item   = '0;
  logic              cfg_valid = 1'b0;
  logic [SLOT_W-1:0] cfg_data  = '0;
  logic              busy;
  logic              out_valid;
  out_t              out_item;
  logic              cfg_ready;
  int                fail_count;
  int                open_count;
  int                quiet_cycles = 0;
  logic              calm = 1'b0;

  logic [SLOT_W-1:0] held_slots [$];
  logic              sent_funcs [$];

  logic [SLOT_W-1:0] phase_size [8] = '{10'd1023, 10'd3, 10'd1, 10'd40,
                                        10'd0, 10'd700, 10'd1023, 10'd9};
  int                phase_items [8] = '{150, 60, 30, 100, 20, 120, 160, 60};

  always #5 clk = ~clk;

  free_list_slot_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fla_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // slots granted so far, so releases can target used slots
  always @(posedge clk) begin : track_grants
    logic f;
    if (rst_n && out_valid === 1'b1 && sent_funcs.size() != 0) begin
      f = sent_funcs.pop_front();
      if (f == FUNC_ALLOC && out_item.ok === 1'b1) held_slots.push_back(out_item.slot_out);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(input logic f, input logic [SLOT_W-1:0] s);
    in_t item;
    item.func    = f;
    item.slot_in = s;
    while (!calm && $urandom_range(0, 99) < 26) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= item;
    @(negedge clk);
    while (busy !== 1'b0) @(negedge clk);
    @(posedge clk);
    sent_funcs.push_back(f);
  endtask

  task automatic release_held();
    int                k;
    logic [SLOT_W-1:0] s;
    if (held_slots.size() == 0) begin
      send_item(FUNC_RELEASE, SLOT_W'($urandom_range(0, DEPTH - 1)));
    end else begin
      k = $urandom_range(0, held_slots.size() - 1);
      s = held_slots[k];
      held_slots.delete(k);
      send_item(FUNC_RELEASE, s);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic set_size(input logic [SLOT_W-1:0] size);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size;
    @(negedge clk);
    while (cfg_ready !== 1'b1) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    held_slots.delete();
  endtask

  initial begin
    int r;
    int alloc_pct;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: grant, double release, out of range, free slot release
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, END_MARK);
    send_item(FUNC_RELEASE, 10'd1022);
    send_item(FUNC_RELEASE, 10'd1022);
    send_item(FUNC_RELEASE, 10'd1023);
    send_item(FUNC_RELEASE, 10'd0);
    send_item(FUNC_ALLOC, '0);

    // zero size: everything fails
    set_size(10'd0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_RELEASE, 10'd0);
    send_item(FUNC_RELEASE, 10'd1023);

    // one slot: empty list after one grant
    set_size(10'd1);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_RELEASE, 10'd0);
    send_item(FUNC_RELEASE, 10'd1);
    send_item(FUNC_ALLOC, 10'd1023);

    set_size(10'd2);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_ALLOC, '0);
    send_item(FUNC_RELEASE, 10'd0);
    send_item(FUNC_RELEASE, 10'd1);
    send_item(FUNC_ALLOC, '0);

    for (int p = 0; p < 8; p++) begin
      set_size(phase_size[p]);
      calm      = (p == 6);
      alloc_pct = (p == 6) ? 70 : 48;
      for (int n = 0; n < phase_items[p]; n++) begin
        if (p == 0 && n == 75) wait_drained();
        r = $urandom_range(0, 99);
        if (r < alloc_pct)
          send_item(FUNC_ALLOC, SLOT_W'($urandom_range(0, DEPTH - 1)));
        else if (r < 88)
          release_held();
        else
          send_item(FUNC_RELEASE, SLOT_W'($urandom_range(0, DEPTH - 1)));
      end
    end
    calm = 1'b0;

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/fla_pkg.sv
hw/rtl/fla_link_store.sv
hw/rtl/free_list_slot_allocator.sv
bench/fla_checker.sv
bench/tb_top.sv
